/* rtl/aept_pkg.sv */
// Shared types, widths and codes for the absolute encoder position tracker.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package aept_pkg;

  localparam int RESOLUTION_BITS_DEFAULT = 14;
  localparam int LUT_BITS_DEFAULT        = 10;

  localparam int ANGLE_W     = 14;
  localparam int PHASE_W     = 12;
  localparam int COUNT_W     = 32;
  localparam int COMMAND_W   = 2;
  localparam int INDEX_W     = 11;
  localparam int OFFSET_W    = 12;
  localparam int PPR_W       = 20;
  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [COMMAND_W-1:0] CMD_READ        = 2'd0;
  localparam logic [COMMAND_W-1:0] CMD_LUT_WRITE   = 2'd1;
  localparam logic [COMMAND_W-1:0] CMD_CLEAR_TURNS = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_LUT_ENABLED       = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_REVERSE_DIRECTION = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ZERO_PHASE_OFFSET = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_PER_REV     = 2'd3;

  localparam logic [PPR_W-1:0] PPR_RESET = 20'd204800;

  typedef struct packed {
    logic                lut_enabled;
    logic                reverse_direction;
    logic [OFFSET_W-1:0] zero_phase_offset;
    logic [PPR_W-1:0]    phase_positions_per_rev;
  } aept_cfg_t;

endpackage

/* rtl/absolute_encoder_position_tracker_unit.sv */
// Top level of the absolute encoder position tracker: configuration registers and ports.
// Depends on aept_pkg, aept_front, aept_queue and aept_back.
`timescale 1ns / 1ps

// The block takes one item per cycle on s_axis, stalls aside. The item's kind travels in
// tuser: an encoder reading, a correction table write, or a clear of the turn count.
// Every item, whatever its kind, gives exactly one result item on the m_axis channel,
// carrying the corrected angle, the direction-adjusted raw angle, the motor phase
// position and the multi-turn position count, with the read error flag in tuser.
// While nothing stalls, items enter every cycle: the table is read once per item and
// written at most once, so the sustained rate is one item per clock. An accepted item
// reaches the result in steps: the table is read as the item is accepted, the corrected
// item then enters the queue, the turn update and multiply happen as it leaves the
// queue, and the phase add lands in the result register. A two-entry queue separates
// the table side from the tracking side, and a result register on the output lets input
// keep flowing while a result waits; when the receiver stalls with items flowing back to
// back, the queue fills and s_axis_tready drops. The cfg channel is always ready and
// writes one register per handshake. The user must make writes only while no items are
// in flight; the block itself does not enforce it. Changing the direction mirrors the
// stored angles and clears the turn count. Reset clears all tracking state and resets
// the registers; the correction table comes up unwritten and needs no clearing pass, but
// every entry that a reading will use must be loaded before the table is enabled.

module absolute_encoder_position_tracker_unit #(
  parameter int RESOLUTION_BITS = aept_pkg::RESOLUTION_BITS_DEFAULT,
  parameter int LUT_BITS        = aept_pkg::LUT_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // raw_angle[13:0], lut_index[24:14], lut_value[38:25], zero pad[39]
  input  logic [39:0]                         s_axis_tdata,
  // command[1:0], read_error[2]
  input  logic [2:0]                          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // angle[13:0], uncorrected_angle[27:14], phase_position[39:28], position_count[71:40]
  output logic [71:0]                         m_axis_tdata,
  // error[0]
  output logic [0:0]                          m_axis_tuser,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [aept_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [aept_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import aept_pkg::*;

  localparam int ENTRY_W = 2 * RESOLUTION_BITS + 3;

  aept_cfg_t          cfg;
  logic               cfg_write;
  logic               flip;

  logic               q_in_valid;
  logic               q_in_ready;
  logic [ENTRY_W-1:0] q_in_data;
  logic               q_out_valid;
  logic               q_out_ready;
  logic [ENTRY_W-1:0] q_out_data;

  logic               out_error;
  logic [ANGLE_W-1:0] out_angle;
  logic [ANGLE_W-1:0] out_uncorrected;
  logic [PHASE_W-1:0] out_phase;
  logic [COUNT_W-1:0] out_count;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  // A direction write that changes the setting mirrors the tracking state.
  assign flip = cfg_write && (cfg_index == CFG_REVERSE_DIRECTION)
                && (cfg_data[0] != cfg.reverse_direction);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lut_enabled             <= 1'b0;
      cfg.reverse_direction       <= 1'b0;
      cfg.zero_phase_offset       <= '0;
      cfg.phase_positions_per_rev <= PPR_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_LUT_ENABLED:       cfg.lut_enabled             <= cfg_data[0];
        CFG_REVERSE_DIRECTION: cfg.reverse_direction       <= cfg_data[0];
        CFG_ZERO_PHASE_OFFSET: cfg.zero_phase_offset       <= cfg_data[OFFSET_W-1:0];
        CFG_PHASE_PER_REV:     cfg.phase_positions_per_rev <= cfg_data[PPR_W-1:0];
        default: ;
      endcase
    end
  end

  aept_front #(
    .RESOLUTION_BITS(RESOLUTION_BITS),
    .LUT_BITS       (LUT_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .in_command   (s_axis_tuser[1:0]),
    .in_raw_angle (s_axis_tdata[13:0]),
    .in_read_error(s_axis_tuser[2]),
    .in_lut_index (s_axis_tdata[24:14]),
    .in_lut_value (s_axis_tdata[38:25]),
    .q_valid      (q_in_valid),
    .q_ready      (q_in_ready),
    .q_data       (q_in_data)
  );

  aept_queue #(
    .WIDTH(ENTRY_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(q_in_valid),
    .push_ready(q_in_ready),
    .push_data (q_in_data),
    .pop_valid (q_out_valid),
    .pop_ready (q_out_ready),
    .pop_data  (q_out_data)
  );

  aept_back #(
    .RESOLUTION_BITS(RESOLUTION_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .flip           (flip),
    .q_valid        (q_out_valid),
    .q_ready        (q_out_ready),
    .q_data         (q_out_data),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .out_error      (out_error),
    .out_angle      (out_angle),
    .out_uncorrected(out_uncorrected),
    .out_phase      (out_phase),
    .out_count      (out_count)
  );

  assign m_axis_tdata = {out_count, out_phase, out_uncorrected, out_angle};
  assign m_axis_tuser = out_error;

endmodule

/* rtl/aept_queue.sv */
// Short first-in first-out queue between the front and back parts of the tracker.
// Depends on aept_pkg for the queue depth.
`timescale 1ns / 1ps

module aept_queue #(
  parameter int WIDTH = 31
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  import aept_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/aept_front.sv */
// Front part: accepts items, keeps the correction table and applies the correction.
// Depends on aept_pkg; feeds aept_queue.
`timescale 1ns / 1ps

module aept_front #(
  parameter int RESOLUTION_BITS = aept_pkg::RESOLUTION_BITS_DEFAULT,
  parameter int LUT_BITS        = aept_pkg::LUT_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  aept_pkg::aept_cfg_t                 cfg,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [aept_pkg::COMMAND_W-1:0]      in_command,
  input  logic [aept_pkg::ANGLE_W-1:0]        in_raw_angle,
  input  logic                                in_read_error,
  input  logic [aept_pkg::INDEX_W-1:0]        in_lut_index,
  input  logic [aept_pkg::ANGLE_W-1:0]        in_lut_value,
  output logic                                q_valid,
  input  logic                                q_ready,
  output logic [2*RESOLUTION_BITS+2:0]        q_data
);
  import aept_pkg::*;

  localparam int WIN_SHIFT = (RESOLUTION_BITS < LUT_BITS) ? 0 : RESOLUTION_BITS - LUT_BITS;
  localparam int TABLE_LEN = (1 << LUT_BITS) + 1;
  localparam int ADDR_W    = LUT_BITS + 1;

  logic [RESOLUTION_BITS-1:0] table_mem [TABLE_LEN];
  logic [RESOLUTION_BITS-1:0] rdata;

  logic                       accept;
  logic [RESOLUTION_BITS-1:0] raw_in;
  logic                       use_upper_in;
  logic [ADDR_W-1:0]          rd_addr;
  logic                       wr_en;

  logic                       f1_valid;
  logic [COMMAND_W-1:0]       f1_command;
  logic                       f1_error;
  logic [RESOLUTION_BITS-1:0] f1_raw;
  logic [RESOLUTION_BITS-1:0] corr;
  logic [RESOLUTION_BITS-1:0] corr_sel;

  assign in_ready = !f1_valid || q_ready;
  assign accept   = in_valid && in_ready;
  assign raw_in   = RESOLUTION_BITS'(in_raw_angle);
  assign rd_addr  = ADDR_W'(raw_in >> WIN_SHIFT) + ADDR_W'(use_upper_in);
  assign wr_en    = accept && (in_command == CMD_LUT_WRITE) && (int'(in_lut_index) < TABLE_LEN);

  // Table: one registered read per accepted item, and one write per in-range table write.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[ADDR_W'(in_lut_index)] <= RESOLUTION_BITS'(in_lut_value);
    end
    if (accept) begin
      rdata <= table_mem[rd_addr];
    end
  end

  generate
    if (WIN_SHIFT == 0) begin : g_direct
      assign use_upper_in = 1'b0;
      assign corr         = rdata;
    end else begin : g_window
      localparam logic [WIN_SHIFT:0] HALF = (WIN_SHIFT + 1)'(1) << (WIN_SHIFT - 1);
      localparam logic [RESOLUTION_BITS-1:0] WIN = RESOLUTION_BITS'(1) << WIN_SHIFT;
      logic [WIN_SHIFT-1:0] off_in;
      logic [WIN_SHIFT-1:0] off_f1;
      logic                 f1_upper;

      assign off_in       = raw_in[WIN_SHIFT-1:0];
      assign off_f1       = f1_raw[WIN_SHIFT-1:0];
      // Past the middle of the window the upper boundary entry is nearer.
      assign use_upper_in = ({1'b0, off_in} > HALF);
      assign corr = f1_upper ? rdata + RESOLUTION_BITS'(off_f1) - WIN
                             : rdata + RESOLUTION_BITS'(off_f1);

      always_ff @(posedge clk) begin
        if (accept) begin
          f1_upper <= use_upper_in;
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (accept) begin
      f1_valid <= 1'b1;
    end else if (q_ready) begin
      f1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_command <= in_command;
      f1_error   <= in_read_error;
      f1_raw     <= raw_in;
    end
  end

  assign corr_sel = cfg.lut_enabled ? corr : f1_raw;
  assign q_valid  = f1_valid;
  assign q_data   = {f1_command, f1_error, f1_raw, corr_sel};

endmodule

/* rtl/aept_back.sv */
// Back part: direction handling, turn counting, phase product and the result register.
// Depends on aept_pkg; drains aept_queue.
`timescale 1ns / 1ps

module aept_back #(
  parameter int RESOLUTION_BITS = aept_pkg::RESOLUTION_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  aept_pkg::aept_cfg_t              cfg,
  input  logic                             flip,
  input  logic                             q_valid,
  output logic                             q_ready,
  input  logic [2*RESOLUTION_BITS+2:0]     q_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_error,
  output logic [aept_pkg::ANGLE_W-1:0]     out_angle,
  output logic [aept_pkg::ANGLE_W-1:0]     out_uncorrected,
  output logic [aept_pkg::PHASE_W-1:0]     out_phase,
  output logic [aept_pkg::COUNT_W-1:0]     out_count
);
  import aept_pkg::*;

  localparam int TURNS_W = COUNT_W - RESOLUTION_BITS;
  localparam int PROD_W  = RESOLUTION_BITS + PPR_W;
  localparam logic [RESOLUTION_BITS-1:0] HALF_REV = RESOLUTION_BITS'(1) << (RESOLUTION_BITS - 1);

  logic [COMMAND_W-1:0]       e_command;
  logic                       e_error;
  logic [RESOLUTION_BITS-1:0] e_raw;
  logic [RESOLUTION_BITS-1:0] e_corr;
  logic                       pop;
  logic                       is_read;
  logic [RESOLUTION_BITS-1:0] ang_new;
  logic [RESOLUTION_BITS-1:0] uncorr_new;
  logic                       wrap_down;
  logic                       wrap_up;

  logic [RESOLUTION_BITS-1:0] current_angle, current_angle_next;
  logic [RESOLUTION_BITS-1:0] last_raw_angle, last_raw_angle_next;
  logic [TURNS_W-1:0]         full_turns, full_turns_next;
  logic [PHASE_W-1:0]         last_phase;

  logic                       m_valid;
  logic                       m_ready;
  logic                       m_error;
  logic                       m_update;
  logic [RESOLUTION_BITS-1:0] m_angle;
  logic [RESOLUTION_BITS-1:0] m_uncorr;
  logic [COUNT_W-1:0]         m_count;
  logic [PROD_W-1:0]          m_prod;
  logic [PHASE_W-1:0]         phase_new;

  logic                       o_ready;
  logic                       o_load;

  assign {e_command, e_error, e_raw, e_corr} = q_data;

  assign o_ready = !out_valid || out_ready;
  assign m_ready = !m_valid || o_ready;
  assign q_ready = m_ready;
  assign pop     = q_valid && m_ready;
  assign o_load  = m_valid && o_ready;

  assign is_read    = (e_command == CMD_READ) && !e_error;
  assign ang_new    = cfg.reverse_direction ? RESOLUTION_BITS'(0) - e_corr : e_corr;
  assign uncorr_new = cfg.reverse_direction ? RESOLUTION_BITS'(0) - e_raw : e_raw;
  // A jump of more than half a turn is a wrap; exactly half counts nothing.
  assign wrap_down  = (ang_new > current_angle) && ((ang_new - current_angle) > HALF_REV);
  assign wrap_up    = (current_angle > ang_new) && ((current_angle - ang_new) > HALF_REV);

  always_comb begin
    current_angle_next  = current_angle;
    last_raw_angle_next = last_raw_angle;
    full_turns_next     = full_turns;
    if (flip) begin
      current_angle_next  = RESOLUTION_BITS'(0) - current_angle;
      last_raw_angle_next = RESOLUTION_BITS'(0) - last_raw_angle;
      full_turns_next     = '0;
    end else if (pop) begin
      if (is_read) begin
        current_angle_next  = ang_new;
        last_raw_angle_next = uncorr_new;
        if (wrap_down) begin
          full_turns_next = full_turns - 1'b1;
        end else if (wrap_up) begin
          full_turns_next = full_turns + 1'b1;
        end
      end else if (e_command == CMD_CLEAR_TURNS) begin
        full_turns_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_angle  <= '0;
      last_raw_angle <= '0;
      full_turns     <= '0;
    end else begin
      current_angle  <= current_angle_next;
      last_raw_angle <= last_raw_angle_next;
      full_turns     <= full_turns_next;
    end
  end

  // Multiply stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (pop) begin
      m_valid <= 1'b1;
    end else if (o_load) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_error  <= (e_command == CMD_READ) && e_error;
      m_update <= is_read;
      m_angle  <= current_angle_next;
      m_uncorr <= last_raw_angle_next;
      m_count  <= {full_turns_next, current_angle_next};
      m_prod   <= PROD_W'(ang_new) * PROD_W'(cfg.phase_positions_per_rev);
    end
  end

  assign phase_new = PHASE_W'(m_prod >> RESOLUTION_BITS) + cfg.zero_phase_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_phase <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (o_load && m_update) begin
        last_phase <= phase_new;
      end
      if (o_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (o_load) begin
      out_error       <= m_error;
      out_angle       <= ANGLE_W'(m_angle);
      out_uncorrected <= ANGLE_W'(m_uncorr);
      out_phase       <= m_update ? phase_new : last_phase;
      out_count       <= m_count;
    end
  end

  a_flip_clears_turns : assert property (@(posedge clk) disable iff (rst)
    flip |=> full_turns == '0)
    else $error("full turns not cleared after a direction change");

  a_clear_command : assert property (@(posedge clk) disable iff (rst)
    (pop && !flip && e_command == CMD_CLEAR_TURNS) |=> full_turns == '0)
    else $error("full turns not cleared by the clear command");

  a_turn_step : assert property (@(posedge clk) disable iff (rst)
    !flip |=> (full_turns == $past(full_turns) || full_turns == $past(full_turns) + 1'b1
               || full_turns == $past(full_turns) - 1'b1 || full_turns == '0))
    else $error("full turns moved by more than one");

  a_mul_stage_holds : assert property (@(posedge clk) disable iff (rst)
    (m_valid && !o_ready) |=> (m_valid && $stable(m_prod) && $stable(m_count)))
    else $error("multiply stage lost its item while stalled");

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for absolute_encoder_position_tracker_unit.
// Depends on aept_pkg and the tracker RTL; all prediction is done locally in a scoreboard class.
`timescale 1ns / 1ps

module tb_top;
  import aept_pkg::*;

  // Command code with no name in the package: the block must treat it as a no-op.
  localparam logic [COMMAND_W-1:0] CMD_UNUSED = 2'd3;

  localparam int LUT_LAST    = 1024;   // duplicate of entry zero
  localparam int WIN_SIZE    = 16;     // angle counts covered by one table window
  localparam int HALF_TURN   = 8192;
  localparam int SETTLE      = 8;      // margin waited out after the last expected result
  localparam int PHASE_ITEMS = 75;
  localparam int PHASES      = 8;

  typedef struct packed {
    logic                err;
    logic [ANGLE_W-1:0]  angle;
    logic [ANGLE_W-1:0]  uncorr;
    logic [PHASE_W-1:0]  phase;
    logic [COUNT_W-1:0]  count;
  } position_t;

  // Tracks the block's state and configuration, and keeps the expected result items
  // in order of the input items that caused them.
  class position_scoreboard;
    bit                 lut_on;
    bit                 reversed;
    bit [OFFSET_W-1:0]  zero_offset;
    bit [PPR_W-1:0]     ppr;
    bit [ANGLE_W-1:0]   cur_angle;
    bit [31:0]          turns;
    bit [ANGLE_W-1:0]   last_raw;
    bit [PHASE_W-1:0]   last_phase;
    bit [ANGLE_W-1:0]   corr_lut [0:LUT_LAST];
    position_t          expected_positions [$];
    int                 failures;

    function new();
      lut_on      = 1'b0;
      reversed    = 1'b0;
      zero_offset = '0;
      ppr         = PPR_RESET;
      cur_angle   = '0;
      turns       = '0;
      last_raw    = '0;
      last_phase  = '0;
      failures    = 0;
      foreach (corr_lut[i]) corr_lut[i] = '0;
    endfunction

    function bit [ANGLE_W-1:0] mirror(bit [ANGLE_W-1:0] a);
      return 14'd0 - a;
    endfunction

    // Nearer window boundary plus or minus the offset into the window.
    function bit [ANGLE_W-1:0] correct(bit [ANGLE_W-1:0] raw);
      int                 idx;
      int                 off;
      bit [ANGLE_W-1:0]   res;
      idx = raw[13:4];
      off = raw[3:0];
      if (off <= WIN_SIZE / 2) res = 14'(corr_lut[idx] + off);
      else res = 14'(corr_lut[idx + 1] - WIN_SIZE + off);
      return res;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_LUT_ENABLED: lut_on = data[0];
        CFG_REVERSE_DIRECTION: begin
          // A change of direction mirrors the held angles and drops the turn count.
          if (data[0] != reversed) begin
            turns     = '0;
            last_raw  = mirror(last_raw);
            cur_angle = mirror(cur_angle);
            reversed  = data[0];
          end
        end
        CFG_ZERO_PHASE_OFFSET: zero_offset = data[OFFSET_W-1:0];
        CFG_PHASE_PER_REV: ppr = data[PPR_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_item(bit [1:0] cmd, bit [13:0] raw, bit rerr, bit [10:0] lidx,
                            bit [13:0] lval);
      bit [ANGLE_W-1:0] ang;
      bit [ANGLE_W-1:0] unc;
      bit [33:0]        prod;
      int               diff;
      int               a_new;
      int               a_old;
      position_t        exp_pos;
      if (cmd == CMD_READ && !rerr) begin
        ang = lut_on ? correct(raw) : raw;
        unc = raw;
        if (reversed) begin
          ang = mirror(ang);
          unc = mirror(raw);
        end
        last_raw   = unc;
        prod       = 34'(ang) * 34'(ppr);
        last_phase = prod[25:14] + zero_offset;
        a_new      = ang;
        a_old      = cur_angle;
        diff       = a_new - a_old;
        // A jump of exactly half a turn is not a wrap.
        if (diff > HALF_TURN) turns = turns - 1;
        else if (diff < -HALF_TURN) turns = turns + 1;
        cur_angle = ang;
      end else if (cmd == CMD_LUT_WRITE) begin
        if (lidx <= LUT_LAST) corr_lut[lidx] = lval;
      end else if (cmd == CMD_CLEAR_TURNS) begin
        turns = '0;
      end
      exp_pos.err    = (cmd == CMD_READ) && rerr;
      exp_pos.angle  = cur_angle;
      exp_pos.uncorr = last_raw;
      exp_pos.phase  = last_phase;
      exp_pos.count  = {turns[17:0], cur_angle};
      expected_positions.push_back(exp_pos);
    endfunction

    function void compare_field(string name, logic [31:0] exp_val, logic [31:0] got_val);
      if (got_val !== exp_val) begin
        $error("%s: expected %0d, actual %0d", name, exp_val, got_val);
        failures++;
      end
    endfunction

    function void check_result(logic [71:0] data, logic [0:0] user);
      position_t exp_pos;
      if (expected_positions.size() == 0) begin
        $error("result item with no expectation waiting: tdata %h", data);
        failures++;
        return;
      end
      exp_pos = expected_positions.pop_front();
      compare_field("error", 32'(exp_pos.err), 32'(user[0]));
      compare_field("angle", 32'(exp_pos.angle), 32'(data[13:0]));
      compare_field("uncorrected_angle", 32'(exp_pos.uncorr), 32'(data[27:14]));
      compare_field("phase_position", 32'(exp_pos.phase), 32'(data[39:28]));
      compare_field("position_count", exp_pos.count, data[71:40]);
    endfunction

    function int pending();
      return expected_positions.size();
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      s_axis_tvalid;
  logic                      s_axis_tready;
  logic [39:0]               s_axis_tdata;    // raw_angle, lut_index, lut_value, zero pad
  logic [2:0]                s_axis_tuser;    // command, read_error
  logic                      m_axis_tvalid;
  logic                      m_axis_tready;
  logic [71:0]               m_axis_tdata;    // angle, uncorrected, phase, position_count
  logic [0:0]                m_axis_tuser;    // error
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_INDEX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]     cfg_data;

  position_scoreboard sb = new();

  int                burst_left = 0;
  bit                steady = 1'b0;    // no idling on either side while set
  bit [ANGLE_W-1:0]  walk_raw = '0;
  bit                walk_up = 1'b1;

  absolute_encoder_position_tracker_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 0;
  end

  // Sends one item. The sender works in bursts; between bursts valid often drops for a
  // random number of cycles, except in steady stretches.
  task automatic send_item(bit [1:0] cmd, bit [13:0] raw, bit rerr, bit [10:0] lidx,
                           bit [13:0] lval);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, lval, lidx, raw};
    s_axis_tuser  <= {rerr, cmd};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_item(cmd, raw, rerr, lidx, lval);
  endtask

  // Stops the sender and waits until every expected result item has come back.
  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Upper bits of the data word are noise; the block keeps only the register's width.
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [PPR_W-1:0] value);
    logic [CFG_DATA_W-1:0] data;
    data = $urandom();
    case (idx)
      CFG_LUT_ENABLED, CFG_REVERSE_DIRECTION: data[0] = value[0];
      CFG_ZERO_PHASE_OFFSET: data[OFFSET_W-1:0] = value[OFFSET_W-1:0];
      default: data[PPR_W-1:0] = value;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // A nearly linear table with a little noise, so that corrected angles still move
  // smoothly and wraps stay meaningful.
  function automatic bit [13:0] smooth_entry(int idx);
    int v;
    v = idx * WIN_SIZE + $urandom_range(0, 80) - 40;
    return v[13:0];
  endfunction

  // Receiver: runs of ready broken by short stalls.
  initial begin
    int run;
    int stall;
    m_axis_tready = 1'b0;
    forever begin
      run   = $urandom_range(1, 24);
      stall = $urandom_range(1, 8);
      repeat (run) begin
        @(negedge clk);
        m_axis_tready <= 1'b1;
      end
      if (!steady) begin
        repeat (stall) begin
          @(negedge clk);
          m_axis_tready <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
  end

  initial begin
    #9_600_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int          r;
    bit [1:0]    cmd;
    bit [13:0]   raw;
    bit          rerr;
    bit [10:0]   lidx;
    bit [13:0]   lval;
    int          step;

    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Load the whole table first, so that no reading can ever touch an unwritten entry.
    for (int i = 0; i <= LUT_LAST; i++) begin
      send_item(CMD_LUT_WRITE, 14'($urandom()), 1'($urandom()), 11'(i),
                (i == LUT_LAST) ? sb.corr_lut[0] : smooth_entry(i));
    end

    // Directed part, table off: wraps in both directions, exact half turns, a failed
    // reading, the non-reading commands and ignored table indexes.
    send_item(CMD_READ, 14'd0, 1'b0, 11'd0, 14'd0);
    send_item(CMD_READ, 14'd16383, 1'b0, 11'd2047, 14'd16383);
    send_item(CMD_READ, 14'd0, 1'b0, 11'd0, 14'd0);
    send_item(CMD_READ, 14'd8192, 1'b0, 11'd0, 14'd0);
    send_item(CMD_READ, 14'd0, 1'b0, 11'd0, 14'd0);
    send_item(CMD_READ, 14'd8193, 1'b0, 11'd0, 14'd0);
    send_item(CMD_READ, 14'd777, 1'b1, 11'd0, 14'd0);
    send_item(CMD_CLEAR_TURNS, 14'd16383, 1'b1, 11'd2047, 14'd16383);
    send_item(CMD_UNUSED, 14'd16383, 1'b1, 11'd2047, 14'd16383);
    send_item(CMD_LUT_WRITE, 14'd0, 1'b0, 11'd2047, 14'd16383);
    send_item(CMD_LUT_WRITE, 14'd0, 1'b0, 11'd1025, 14'd5);
    send_item(CMD_LUT_WRITE, 14'd0, 1'b0, 11'd0, 14'd0);
    send_item(CMD_LUT_WRITE, 14'd0, 1'b0, 11'd1024, 14'd0);
    send_item(CMD_LUT_WRITE, 14'd0, 1'b0, 11'd1023, 14'd16383);
    drain();

    // Table on: offsets at and around the window midpoint, and the top window that
    // uses the duplicate end entry.
    write_reg(CFG_LUT_ENABLED, 20'd1);
    send_item(CMD_READ, 14'd0, 1'b0, 11'd0, 14'd0);
    send_item(CMD_READ, 14'd8, 1'b0, 11'd0, 14'd0);
    send_item(CMD_READ, 14'd9, 1'b0, 11'd0, 14'd0);
    send_item(CMD_READ, 14'd15, 1'b0, 11'd0, 14'd0);
    send_item(CMD_READ, 14'd16383, 1'b0, 11'd0, 14'd0);
    send_item(CMD_READ, 14'd16376, 1'b0, 11'd0, 14'd0);
    send_item(CMD_READ, 14'd16377, 1'b0, 11'd0, 14'd0);
    drain();

    // Reversing mirrors the held angles and clears the turns.
    write_reg(CFG_REVERSE_DIRECTION, 20'd1);
    send_item(CMD_READ, 14'd1, 1'b0, 11'd0, 14'd0);
    send_item(CMD_READ, 14'd8192, 1'b0, 11'd0, 14'd0);
    send_item(CMD_READ, 14'd4321, 1'b1, 11'd0, 14'd0);
    drain();

    // Random part: one register setting per phase, extremes in the first four.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          write_reg(CFG_LUT_ENABLED, 20'd0);
          write_reg(CFG_REVERSE_DIRECTION, 20'd0);
          write_reg(CFG_ZERO_PHASE_OFFSET, 20'd0);
          write_reg(CFG_PHASE_PER_REV, PPR_RESET);
        end
        1: begin
          write_reg(CFG_LUT_ENABLED, 20'd1);
          write_reg(CFG_REVERSE_DIRECTION, 20'd0);
          write_reg(CFG_ZERO_PHASE_OFFSET, 20'd4095);
          write_reg(CFG_PHASE_PER_REV, 20'd1048575);
        end
        2: begin
          write_reg(CFG_LUT_ENABLED, 20'd1);
          write_reg(CFG_REVERSE_DIRECTION, 20'd1);
          write_reg(CFG_ZERO_PHASE_OFFSET, 20'($urandom_range(0, 4095)));
          write_reg(CFG_PHASE_PER_REV, 20'd1);
        end
        3: begin
          write_reg(CFG_LUT_ENABLED, 20'd0);
          write_reg(CFG_REVERSE_DIRECTION, 20'd1);
          write_reg(CFG_ZERO_PHASE_OFFSET, 20'($urandom_range(0, 4095)));
          write_reg(CFG_PHASE_PER_REV, 20'd0);
        end
        default: begin
          write_reg(CFG_LUT_ENABLED, 20'($urandom_range(0, 1)));
          write_reg(CFG_REVERSE_DIRECTION, 20'($urandom_range(0, 1)));
          // Toggling twice must leave the direction as it was, turns cleared.
          if (p == 6) begin
            write_reg(CFG_REVERSE_DIRECTION, 20'(!sb.reversed));
            write_reg(CFG_REVERSE_DIRECTION, 20'(!sb.reversed));
          end
          write_reg(CFG_ZERO_PHASE_OFFSET, 20'($urandom_range(0, 4095)));
          write_reg(CFG_PHASE_PER_REV, ($urandom_range(0, 1) == 1) ?
                    20'($urandom()) : 20'($urandom_range(1, 4096)));
        end
      endcase
      steady  = (p == 1 || p == 5);
      walk_up = $urandom_range(0, 1);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r    = $urandom_range(0, 99);
        raw  = 14'($urandom());
        rerr = 1'b0;
        lidx = 11'($urandom());
        lval = 14'($urandom());
        if (r < 82) begin
          cmd = CMD_READ;
          // Mostly a drifting shaft, so that turns accumulate; now and then a jump,
          // an exact half turn, an extreme angle or a failed reading.
          r = $urandom_range(0, 99);
          if (r < 60) begin
            if ($urandom_range(0, 49) == 0) walk_up = !walk_up;
            step = $urandom_range(0, 600);
            walk_raw = walk_up ? 14'(walk_raw + step) : 14'(walk_raw - step);
            raw = walk_raw;
          end else if (r < 75) begin
            walk_raw = raw;
          end else if (r < 83) begin
            walk_raw = walk_raw ^ 14'h2000;
            raw = walk_raw;
          end else if (r < 91) begin
            case ($urandom_range(0, 3))
              0: raw = 14'd0;
              1: raw = 14'd16383;
              2: raw = 14'd8191;
              default: raw = 14'd8192;
            endcase
            walk_raw = raw;
          end else begin
            rerr = 1'b1;
          end
        end else if (r < 90) begin
          cmd = CMD_LUT_WRITE;
          r = $urandom_range(0, 9);
          if (r < 6) begin
            lidx = 11'($urandom_range(0, LUT_LAST));
            lval = smooth_entry(lidx);
          end else if (r < 8) begin
            lidx = 11'($urandom_range(0, LUT_LAST));
          end else begin
            lidx = 11'($urandom_range(LUT_LAST + 1, 2047));
          end
          rerr = 1'($urandom());
        end else if (r < 96) begin
          cmd  = CMD_CLEAR_TURNS;
          rerr = 1'($urandom());
        end else begin
          cmd  = CMD_UNUSED;
          rerr = 1'($urandom());
        end
        send_item(cmd, raw, rerr, lidx, lval);
      end
      drain();
    end

    if (sb.failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
